// ----- sv/bdq_pkg.sv -----
// Shared types and constants for the bounded deque with search.
// Operation kinds, status codes, field widths and controller/datapath structs.
// No dependencies.
package bdq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam logic [KIND_W-1:0] K_PUSH_BACK  = 3'd0;
    localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] K_POP_BACK   = 3'd2;
    localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] K_FIND       = 3'd4;
    localparam logic [KIND_W-1:0] K_SIZE       = 3'd5;
    localparam logic [KIND_W-1:0] K_REVERSE    = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic exec;        // operation without a scan, result loads at this edge
        logic scan_start;  // find on a non-empty queue begins
        logic scan_load;   // scan finished, load find result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cnt_zero;
        logic scan_done;
    } t_sts;

endpackage

// ----- sv/bdq_in_if.sv -----
// Request channel: valid/ready handshake carrying one deque operation.
// Depends on bdq_pkg.
interface bdq_in_if;
    import bdq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- sv/bdq_out_if.sv -----
// Response channel: valid/ready handshake carrying one operation result.
// Depends on bdq_pkg.
interface bdq_out_if;
    import bdq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output found, output position,
                    output count, input ready);
    modport sink   (input valid, input status, input found, input position,
                    input count, output ready);
endinterface

// ----- sv/bdq_datapath.sv -----
// Datapath: ring store memory, front/count/direction registers, find scan
// pipeline (address stage, registered read, compare) and result registers.
// Depends on bdq_pkg.
module bdq_datapath #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [bdq_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [bdq_pkg::VALUE_W-1:0] i_value,
    input  bdq_pkg::t_cmd                      i_cmd,
    output bdq_pkg::t_sts                      o_sts,
    output logic [bdq_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_found,
    output logic [bdq_pkg::POS_W-1:0]          o_position,
    output logic [bdq_pkg::COUNT_W-1:0]        o_count
);
    import bdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_X = (IDX_W+1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]    r_front, n_front;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_rev, n_rev;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_found;
    logic [POS_W-1:0]    r_pos;

    // scan pipeline
    logic [VALUE_W-1:0]  r_key;
    logic                r_addr_vld;
    logic [IDX_W-1:0]    r_addr_idx;
    logic [IDX_W-1:0]    r_scan_addr;
    logic                r_data_vld;
    logic [IDX_W-1:0]    r_data_idx;
    logic [VALUE_W-1:0]  r_rd_data;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W:0]      tail_sum, last_sum;
    logic [IDX_W-1:0]    tail_addr, last_addr, front_inc, front_dec, step_addr;
    logic [CNT_W-1:0]    cnt_m1;
    logic                full, at_tail, match, data_last, addr_last;

    assign full      = (r_cnt == DEPTH_C);
    assign cnt_m1    = r_cnt - 1'b1;
    assign tail_sum  = {1'b0, r_front} + (IDX_W+1)'(r_cnt);
    assign tail_addr = (tail_sum >= DEPTH_X) ? IDX_W'(tail_sum - DEPTH_X) : IDX_W'(tail_sum);
    assign last_sum  = {1'b0, r_front} + (IDX_W+1)'(cnt_m1);
    assign last_addr = (last_sum >= DEPTH_X) ? IDX_W'(last_sum - DEPTH_X) : IDX_W'(last_sum);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - 1'b1;

    // reversed scan walks the ring backward from the physical tail
    always_comb begin
        if (r_rev) begin
            step_addr = (r_scan_addr == '0) ? LAST_IDX : r_scan_addr - 1'b1;
        end else begin
            step_addr = (r_scan_addr == LAST_IDX) ? '0 : r_scan_addr + 1'b1;
        end
    end

    assign match     = r_data_vld && (r_rd_data == r_key);
    assign data_last = r_data_vld && (CNT_W'(r_data_idx) == cnt_m1);
    assign addr_last = (CNT_W'(r_addr_idx) == cnt_m1);

    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.scan_done = match || data_last;

    always_comb begin
        n_front  = r_front;
        n_cnt    = r_cnt;
        n_rev    = r_rev;
        n_status = ST_OK;
        wr_en    = 1'b0;
        wr_addr  = tail_addr;
        at_tail  = 1'b0;
        case (i_kind)
            K_PUSH_BACK, K_PUSH_FRONT: begin
                at_tail = (i_kind == K_PUSH_BACK) ^ r_rev;
                if (full) begin
                    n_status = ST_FULL;
                end else if (at_tail) begin
                    wr_en = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = front_dec;
                    n_front = front_dec;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            K_POP_BACK, K_POP_FRONT: begin
                at_tail = (i_kind == K_POP_BACK) ^ r_rev;
                if (r_cnt == '0) begin
                    n_status = ST_EMPTY;
                end else if (at_tail) begin
                    n_cnt = cnt_m1;
                end else begin
                    n_front = front_inc;
                    n_cnt   = cnt_m1;
                end
            end
            K_FIND:    n_status = ST_NOT_FOUND;  // exec only sees find on empty
            K_REVERSE: n_rev    = ~r_rev;
            default:   n_status = ST_OK;
        endcase
        if (!i_cmd.exec) begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_cnt   <= '0;
            r_rev   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_cnt   <= n_cnt;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_vld <= 1'b0;
            r_data_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_addr_vld <= 1'b1;
            r_data_vld <= 1'b0;
        end else if (i_cmd.scan_load) begin
            r_addr_vld <= 1'b0;
            r_data_vld <= 1'b0;
        end else begin
            r_addr_vld <= r_addr_vld && !addr_last;
            r_data_vld <= r_addr_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_key       <= i_value;
            r_addr_idx  <= '0;
            r_scan_addr <= r_rev ? last_addr : r_front;
        end else if (r_addr_vld) begin
            r_addr_idx  <= r_addr_idx + 1'b1;
            r_scan_addr <= step_addr;
        end
        r_data_idx <= r_addr_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_found  <= 1'b0;
            r_pos    <= '0;
        end else if (i_cmd.scan_load) begin
            r_status <= match ? ST_OK : ST_NOT_FOUND;
            r_found  <= match;
            r_pos    <= match ? POS_W'(r_data_idx) : '0;
        end
    end

    assign o_status   = r_status;
    assign o_found    = r_found;
    assign o_position = r_pos;
    assign o_count    = COUNT_W'(r_cnt);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C)
        else $error("element count exceeds depth");

    a_data_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_vld |-> (CNT_W'(r_data_idx) < r_cnt))
        else $error("scan compares beyond stored elements");

    a_scan_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_start |=> (r_addr_vld && !r_data_vld && r_addr_idx == '0))
        else $error("scan pipeline not primed on start");
endmodule

// ----- sv/bdq_ctrl.sv -----
// Controller: idle/scan state machine, handshake control and result valid.
// Depends on bdq_pkg.
module bdq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [bdq_pkg::KIND_W-1:0] i_kind,
    input  logic                       i_out_ready,
    input  bdq_pkg::t_sts              i_sts,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    output bdq_pkg::t_cmd              o_cmd
);
    import bdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, is_find;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign is_find    = (i_kind == K_FIND);

    assign o_cmd.exec       = accept && !(is_find && !i_sts.cnt_zero);
    assign o_cmd.scan_start = accept && is_find && !i_sts.cnt_zero;
    assign o_cmd.scan_load  = (r_state == S_SCAN) && i_sts.scan_done;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.exec) begin
                    n_out_valid = 1'b1;
                end
                if (o_cmd.scan_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_scan_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_out_valid)
        else $error("result pending while a find scan runs");

    a_scan_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_start |=> (r_state == S_SCAN))
        else $error("find did not enter scan");

    a_scan_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_load |=> (r_state == S_IDLE && r_out_valid))
        else $error("scan end did not present a result");
endmodule

// ----- sv/bounded_deque_with_search_core.sv -----
// Bounded double-ended queue of signed 32-bit values held in a DEPTH-entry
// ring memory, with push/pop at either end, size, reverse and find. Push, pop,
// size, reverse and find on an empty queue complete without a scan, and a new
// request is taken in the same cycle the previous response is taken. Find
// walks the stored elements from the logical front through one memory read
// port with a registered read, stopping at the first match or after the last
// stored element. No clearing pass is needed after reset; memory contents are
// read only where written.
// Depends on bdq_pkg, bdq_in_if, bdq_out_if, bdq_ctrl and bdq_datapath.
module bounded_deque_with_search_core #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bdq_in_if.sink   i_req,
    bdq_out_if.source o_rsp
);
    import bdq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_kind      (i_req.kind),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_kind     (i_req.kind),
        .i_value    (i_req.value),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_status   (o_rsp.status),
        .o_found    (o_rsp.found),
        .o_position (o_rsp.position),
        .o_count    (o_rsp.count)
    );
endmodule
